/* rtl/core/serial_command_frame_parser_core_assert.svh */
// Assertion macros shared by the serial command frame parser RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef SERIAL_COMMAND_FRAME_PARSER_CORE_ASSERT_SVH
`define SERIAL_COMMAND_FRAME_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SCFP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SCFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/scfp_pkg.sv */
// Shared types and constants of the serial command frame parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package scfp_pkg;

  // Register indexes of the configuration port.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDRESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_VALUE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_VALUE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UPGRADE_CODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS_CODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPLY_MASK    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REPLY_LENGTH  = 3'd6;

  // Reset values of the registers.
  localparam logic [7:0] RST_SLAVE_ADDRESS = 8'd1;
  localparam logic [7:0] RST_HEAD_VALUE    = 8'd170;
  localparam logic [7:0] RST_TAIL_VALUE    = 8'd85;
  localparam logic [7:0] RST_UPGRADE_CODE  = 8'd5;
  localparam logic [7:0] RST_BYPASS_CODE   = 8'd6;
  localparam logic [7:0] RST_REPLY_MASK    = 8'd128;
  localparam logic [7:0] RST_REPLY_LENGTH  = 8'd3;

  // Frame constants.
  localparam logic [7:0] CHECK_BYTE = 8'hFF;
  localparam logic [7:0] LEN_OFFSET = 8'd3;

  // Positions of the bytes within a reply frame.
  localparam logic [2:0] POS_HEAD   = 3'd0;
  localparam logic [2:0] POS_CMD    = 3'd1;
  localparam logic [2:0] POS_LEN    = 3'd2;
  localparam logic [2:0] POS_CHK_H  = 3'd3;
  localparam logic [2:0] POS_CHK_L  = 3'd4;
  localparam logic [2:0] POS_TAIL   = 3'd5;

  // Reply queue geometry.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  // Live register values.
  typedef struct packed {
    logic [7:0] slave_address;
    logic [7:0] head_value;
    logic [7:0] tail_value;
    logic [7:0] upgrade_code;
    logic [7:0] bypass_code;
    logic [7:0] reply_mask;
    logic [7:0] reply_length;
  } cfg_t;

  // One queued reply, as classified by the parser.
  typedef struct packed {
    logic [7:0] cmd_byte;
    logic       upgrade;
    logic       bypass;
  } reply_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

/* rtl/core/serial_command_frame_parser_core.sv */
// Serial command frame parser: one received byte per cycle, six-byte replies.
// After the tail transfer the reply goes through the queue and then the output register.
// Throughput: one rx byte per cycle while in_ready is high, one reply byte per cycle
// while out_ready is high; two-entry queue, in_ready falls only while both are held.
// Reset: synchronous, active low; registers return to their defaults, parser to head.
`default_nettype none

module serial_command_frame_parser_core (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [7:0]                     out_tx_byte,
  output logic                           out_last_byte,
  output logic                           out_upgrade_request,
  output logic                           out_bypass_active,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [scfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [7:0]                     cfg_data
);
  import scfp_pkg::*;

  cfg_t      cfg_r;
  reply_t    push_data, head_data;
  q_status_t status;
  logic      push, pop, rx_take;

  assign cfg_ready = 1'b1;
  assign in_ready  = !status.full;
  assign rx_take   = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slave_address <= RST_SLAVE_ADDRESS;
      cfg_r.head_value    <= RST_HEAD_VALUE;
      cfg_r.tail_value    <= RST_TAIL_VALUE;
      cfg_r.upgrade_code  <= RST_UPGRADE_CODE;
      cfg_r.bypass_code   <= RST_BYPASS_CODE;
      cfg_r.reply_mask    <= RST_REPLY_MASK;
      cfg_r.reply_length  <= RST_REPLY_LENGTH;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SLAVE_ADDRESS: cfg_r.slave_address <= cfg_data;
        REG_HEAD_VALUE:    cfg_r.head_value    <= cfg_data;
        REG_TAIL_VALUE:    cfg_r.tail_value    <= cfg_data;
        REG_UPGRADE_CODE:  cfg_r.upgrade_code  <= cfg_data;
        REG_BYPASS_CODE:   cfg_r.bypass_code   <= cfg_data;
        REG_REPLY_MASK:    cfg_r.reply_mask    <= cfg_data;
        REG_REPLY_LENGTH:  cfg_r.reply_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: frame parser.
  scfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_take   (rx_take),
    .rx_byte   (in_rx_byte),
    .cfg       (cfg_r),
    .push      (push),
    .push_data (push_data)
  );

  // Reply queue.
  scfp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .status    (status)
  );

  // Back end: reply serialiser.
  scfp_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .head_data           (head_data),
    .status              (status),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_tx_byte         (out_tx_byte),
    .out_last_byte       (out_last_byte),
    .out_upgrade_request (out_upgrade_request),
    .out_bypass_active   (out_bypass_active)
  );

endmodule

`default_nettype wire

/* rtl/core/scfp_front.sv */
// Frame parser front end: walks request frames one byte per transfer.
// Uses scfp_pkg; queues a reply descriptor on a good upgrade or bypass tail.
`default_nettype none
`include "serial_command_frame_parser_core_assert.svh"

module scfp_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  rx_take,
  input  wire  [7:0]           rx_byte,
  input  scfp_pkg::cfg_t       cfg,
  output logic                 push,
  output scfp_pkg::reply_t     push_data
);
  import scfp_pkg::*;

  typedef enum logic [2:0] {
    PH_HEAD, PH_ADDR, PH_CMD, PH_LEN, PH_DATA, PH_CHK_H, PH_CHK_L, PH_TAIL
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic [7:0] left_r, left_nxt;
  logic       bypass_r, bypass_nxt;
  logic [7:0] left_dec;

  assign left_dec = left_r - 8'd1;

  // Next-state decode for one received byte.
  always_comb begin
    phase_nxt  = phase_r;
    held_nxt   = held_r;
    left_nxt   = left_r;
    bypass_nxt = bypass_r;
    push       = 1'b0;
    push_data  = '{cmd_byte: held_r | cfg.reply_mask, upgrade: 1'b0, bypass: bypass_r};
    if (rx_take) begin
      case (phase_r)
        PH_HEAD: begin
          if (rx_byte == cfg.head_value) phase_nxt = PH_ADDR;
        end
        PH_ADDR: begin
          phase_nxt = (rx_byte == cfg.slave_address) ? PH_CMD : PH_HEAD;
        end
        PH_CMD: begin
          if (rx_byte <= cfg.bypass_code) begin
            held_nxt  = rx_byte;
            phase_nxt = PH_LEN;
          end else begin
            phase_nxt = PH_HEAD;
          end
        end
        PH_LEN: begin
          left_nxt  = rx_byte - LEN_OFFSET;
          phase_nxt = (left_nxt != 8'd0) ? PH_DATA : PH_CHK_H;
        end
        PH_DATA: begin
          // An empty counter here cannot arise from a legal frame; drop back.
          if (left_r == 8'd0) begin
            phase_nxt = PH_HEAD;
          end else begin
            left_nxt = left_dec;
            if (left_dec == 8'd0) phase_nxt = PH_CHK_H;
          end
        end
        PH_CHK_H: begin
          phase_nxt = (rx_byte == CHECK_BYTE) ? PH_CHK_L : PH_HEAD;
        end
        PH_CHK_L: begin
          phase_nxt = (rx_byte == CHECK_BYTE) ? PH_TAIL : PH_HEAD;
        end
        default: begin
          // Upgrade takes priority when both codes are equal.
          if (rx_byte == cfg.tail_value) begin
            if (held_r == cfg.upgrade_code) begin
              push              = 1'b1;
              push_data.upgrade = 1'b1;
            end else if (held_r == cfg.bypass_code) begin
              push             = 1'b1;
              bypass_nxt       = 1'b1;
              push_data.bypass = 1'b1;
            end
          end
          phase_nxt = PH_HEAD;
        end
      endcase
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEAD;
      held_r   <= 8'd0;
      left_r   <= 8'd0;
      bypass_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      held_r   <= held_nxt;
      left_r   <= left_nxt;
      bypass_r <= bypass_nxt;
    end
  end

  `SCFP_ASSERT_NEXT(a_bypass_sticky, bypass_r, bypass_r, "bypass mode cleared outside reset")
  `SCFP_ASSERT_IMPL(a_push_on_tail, push, rx_take && (phase_r == PH_TAIL),
                    "reply queued outside the tail phase")

endmodule

`default_nettype wire

/* rtl/core/scfp_queue.sv */
// Short reply queue between the parser and the reply serialiser.
// Depends on scfp_pkg; register-based, depth Q_DEPTH.
`default_nettype none
`include "serial_command_frame_parser_core_assert.svh"

module scfp_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  scfp_pkg::reply_t      push_data,
  input  wire                   pop,
  output scfp_pkg::reply_t      head_data,
  output scfp_pkg::q_status_t   status
);
  import scfp_pkg::*;

  reply_t            slot_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   count_r, count_nxt;

  assign status.full  = (count_r == Q_CW'(Q_DEPTH));
  assign status.empty = (count_r == '0);
  assign head_data    = slot_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? Q_AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? Q_AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r + Q_CW'(push) - Q_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  `SCFP_ASSERT_IMPL(a_no_push_full, push, !status.full, "reply pushed into a full queue")
  `SCFP_ASSERT_IMPL(a_no_pop_empty, pop, !status.empty, "reply popped from an empty queue")

endmodule

`default_nettype wire

/* rtl/core/scfp_back.sv */
// Reply serialiser: turns the queue head into six reply bytes.
// Depends on scfp_pkg; drives the registered result channel.
`default_nettype none
`include "serial_command_frame_parser_core_assert.svh"

module scfp_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  scfp_pkg::cfg_t        cfg,
  input  scfp_pkg::reply_t      head_data,
  input  scfp_pkg::q_status_t   status,
  output logic                  pop,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [7:0]            out_tx_byte,
  output logic                  out_last_byte,
  output logic                  out_upgrade_request,
  output logic                  out_bypass_active
);
  import scfp_pkg::*;

  logic       valid_r, valid_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic [7:0] byte_r;
  logic       last_r, upgrade_r, bypass_r;
  logic       load;
  logic       emit;
  logic [7:0] cur_byte;
  logic       cur_last;

  // The output register refills whenever it is empty or being taken.
  assign load     = !valid_r || out_ready;
  assign emit     = load && !status.empty;
  assign cur_last = (pos_r == POS_TAIL);
  assign pop      = emit && cur_last;

  // Byte of the reply frame at the current position.
  always_comb begin
    case (pos_r)
      POS_HEAD:  cur_byte = cfg.head_value;
      POS_CMD:   cur_byte = head_data.cmd_byte;
      POS_LEN:   cur_byte = cfg.reply_length;
      POS_CHK_H: cur_byte = CHECK_BYTE;
      POS_CHK_L: cur_byte = CHECK_BYTE;
      default:   cur_byte = cfg.tail_value;
    endcase
  end

  always_comb begin
    valid_nxt = load ? !status.empty : valid_r;
    pos_nxt   = pos_r;
    if (emit) pos_nxt = cur_last ? POS_HEAD : pos_r + 3'd1;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pos_r   <= POS_HEAD;
    end else begin
      valid_r <= valid_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r    <= cur_byte;
      last_r    <= cur_last;
      upgrade_r <= head_data.upgrade;
      bypass_r  <= head_data.bypass;
    end
  end

  assign out_valid           = valid_r;
  assign out_tx_byte         = byte_r;
  assign out_last_byte       = last_r;
  assign out_upgrade_request = upgrade_r;
  assign out_bypass_active   = bypass_r;

  `SCFP_ASSERT_NEXT(a_reply_no_gap, valid_r && out_ready && !last_r, valid_r,
                    "gap inside a reply frame")
  `SCFP_ASSERT_IMPL(a_pos_range, 1'b1, pos_r <= POS_TAIL, "reply position out of range")

endmodule

`default_nettype wire
